>>> sv/mvm_pkg.sv
// shared types and constants for the int16 matrix-vector multiply unit
package mvm_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned COLS_CFG_W = 11;
  localparam int unsigned ROWS_CFG_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [COLS_CFG_W-1:0] MAX_COLS = 11'd1024;
  localparam logic [ROWS_CFG_W-1:0] MAX_ROWS = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 2'd0,
    CFG_COL_COUNT = 2'd1
  } cfg_idx_t;

  typedef enum logic {
    KIND_VECTOR = 1'b0,
    KIND_MATRIX = 1'b1
  } kind_t;

  typedef struct packed {
    logic               kind;
    logic [COL_W-1:0]   vector_index;
    logic signed [15:0] value;
  } mvm_req_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    logic [ROW_W-1:0]   row_index;
    logic               last;
  } mvm_res_t;

  // control that follows a matrix element into the mac stage
  typedef struct packed {
    logic             valid;
    logic             end_row;
    logic             final_row;
    logic [ROW_W-1:0] row_index;
  } mvm_mac_ctl_t;

endpackage

>>> sv/int16_matrix_vector_multiply_unit.sv
// top level of the int16 matrix-vector multiply unit
//
//  channel   | signals                            | accepted when
//  ----------+------------------------------------+---------------------------
//  request   | start, busy, request               | start && !busy
//  result    | result_valid, result               | result_valid (no stall)
//  config    | cfg_valid, cfg_ready, cfg_index,   | cfg_valid && cfg_ready
//            | cfg_data                           |
//
// one request per cycle; busy stays low and cfg_ready stays high.
// a matrix element reads the vector ram at its accept edge, the mac stage
// adds the product in the following cycle and the row result is shown the cycle after.
// rst is synchronous and clears counters, row sum and strobes; vector ram is
// not cleared. the receiver cannot stall the result strobe.
module int16_matrix_vector_multiply_unit
  import mvm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  mvm_req_t              request,
  output logic                  result_valid,
  output mvm_res_t              result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                  accept;
  logic [ROWS_CFG_W-1:0] row_count;
  logic [COLS_CFG_W-1:0] col_count;
  logic [ROWS_CFG_W-1:0] rows;
  logic [COLS_CFG_W-1:0] cols;
  logic [COL_W-1:0]      column_position;
  logic [ROW_W-1:0]      row_position;
  logic                  end_row;
  logic                  final_row;
  logic                  is_matrix;
  logic [DATA_W-1:0]     x_data;
  mvm_mac_ctl_t          issue_ctl;
  mvm_mac_ctl_t          stage_ctl;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign is_matrix = (request.kind == KIND_MATRIX);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROWS_CFG_W'(1);
      col_count <= COLS_CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROW_COUNT: row_count <= cfg_data[ROWS_CFG_W-1:0];
        CFG_COL_COUNT: col_count <= cfg_data[COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers into their legal ranges
  always_comb begin
    if (col_count == '0) begin
      cols = COLS_CFG_W'(1);
    end else if (col_count > MAX_COLS) begin
      cols = MAX_COLS;
    end else begin
      cols = col_count;
    end
    if (row_count == '0) begin
      rows = ROWS_CFG_W'(1);
    end else if (row_count > MAX_ROWS) begin
      rows = MAX_ROWS;
    end else begin
      rows = row_count;
    end
  end

  assign end_row   = ({1'b0, column_position} + COLS_CFG_W'(1)) >= cols;
  assign final_row = ({1'b0, row_position} + ROWS_CFG_W'(1)) >= rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (accept && is_matrix) begin
      if (end_row) begin
        column_position <= '0;
        row_position    <= final_row ? '0 : row_position + ROW_W'(1);
      end else begin
        column_position <= column_position + COL_W'(1);
      end
    end
  end

  always_comb begin
    issue_ctl.valid     = accept && is_matrix;
    issue_ctl.end_row   = end_row;
    issue_ctl.final_row = final_row;
    issue_ctl.row_index = row_position;
  end

  mvm_vec_ram u_ram (
    .clk   (clk),
    .we    (accept && !is_matrix),
    .waddr (request.vector_index),
    .wdata (request.value),
    .re    (accept && is_matrix),
    .raddr (column_position),
    .rdata (x_data)
  );

  mvm_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .issue_ctl    (issue_ctl),
    .issue_value  (request.value),
    .x_data       (x_data),
    .stage_ctl    (stage_ctl),
    .result_valid (result_valid),
    .result       (result)
  );

  a_result_from_matrix: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(accept && is_matrix && end_row, 2))
    else $error("result without a row-ending matrix request");

  a_no_result_mid_row: assert property (@(posedge clk) disable iff (rst)
    stage_ctl.valid && !stage_ctl.end_row |=> !result_valid)
    else $error("result strobe in the middle of a row");

  a_last_resets_row: assert property (@(posedge clk) disable iff (rst)
    accept && is_matrix && end_row && final_row |=> row_position == '0)
    else $error("row position not cleared after final row");

endmodule

>>> sv/mvm_vec_ram.sv
// vector store: single-port-write, single-read ram with registered read data
module mvm_vec_ram
  import mvm_pkg::*;
(
  input  logic                  clk,
  input  logic                  we,
  input  logic [COL_W-1:0]      waddr,
  input  logic [DATA_W-1:0]     wdata,
  input  logic                  re,
  input  logic [COL_W-1:0]      raddr,
  output logic [DATA_W-1:0]     rdata
);

  logic [DATA_W-1:0] mem [2**COL_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/mvm_mac.sv
// multiply-accumulate stage: row sum and result register
module mvm_mac
  import mvm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mvm_mac_ctl_t      issue_ctl,
  input  logic [DATA_W-1:0] issue_value,
  input  logic [DATA_W-1:0] x_data,
  output mvm_mac_ctl_t      stage_ctl,
  output logic              result_valid,
  output mvm_res_t          result
);

  logic [DATA_W-1:0] stage_value;
  logic [DATA_W-1:0] row_sum;
  logic [DATA_W-1:0] row_sum_next;
  logic [DATA_W-1:0] prod;
  logic [2*DATA_W-1:0] prod_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_ctl <= '0;
    end else begin
      stage_ctl <= issue_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_ctl.valid) begin
      stage_value <= issue_value;
    end
  end

  // wrapping product, low half only
  assign prod_full    = stage_value * x_data;
  assign prod         = prod_full[DATA_W-1:0];
  assign row_sum_next = row_sum + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= stage_ctl.valid && stage_ctl.end_row;
      if (stage_ctl.valid) begin
        row_sum <= stage_ctl.end_row ? '0 : row_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ctl.valid && stage_ctl.end_row) begin
      result.result_value <= row_sum_next;
      result.row_index    <= stage_ctl.row_index;
      result.last         <= stage_ctl.final_row;
    end
  end

endmodule
